// File: src/exact_pattern_match_counter_macros.svh
// Assertion macros for the exact pattern match counter.
`ifndef EXACT_PATTERN_MATCH_COUNTER_MACROS_SVH
`define EXACT_PATTERN_MATCH_COUNTER_MACROS_SVH

`ifndef SYNTH
// Condition holds on every clock outside reset.
`define EPMC_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define EPMC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the next cycle.
`define EPMC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EPMC_ASSERT(name, cond, msg)
`define EPMC_ASSERT_IMP(name, ante, cons, msg)
`define EPMC_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// File: src/epmc_pkg.sv
// Package with sizes, function codes and helpers of the exact pattern match counter.
`timescale 1ns / 1ps

package epmc_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int CNT_W       = 32;
    localparam int CFG_W       = 6;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        FUNC_PATTERN = 2'd0,
        FUNC_TEXT    = 2'd1,
        FUNC_END     = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef logic [PATTERN_MAX-1:0][7:0] byte_vec_t;

    // zero acts as one, anything above the store depth acts as the depth
    function automatic logic [LEN_W-1:0] eff_length(input logic [CFG_W-1:0] raw);
        int r;
        r = int'(raw);
        if (r == 0)
        begin
            r = 1;
        end
        if (r > PATTERN_MAX)
        begin
            r = PATTERN_MAX;
        end
        return LEN_W'(r);
    endfunction

endpackage

// File: src/exact_pattern_match_counter.sv
// Exact pattern match counter: pattern store, text window compare and counters.
// Usage:
//   Slave stream s_axis carries one word per item: tuser holds the function
//   (pattern write, text byte, end of text), tdata the byte and pattern slot.
//   Master stream m_axis returns one word per accepted item: found flag,
//   start offset, running match count and end-of-text flag. cfg_wr_en/cfg_wr_data
//   set the pattern length; write it only while the block is idle (the block never checks).
// Pipeline: an accepted word is held in the input register; its result is then
//   registered in the result register and presented on m_axis.
// Throughput: one word per cycle while m_axis_tready is high. The register-to-register
//   loop is the window compare against the length-aligned pattern copy plus the 32-bit
//   saturating count and offset update.
// Reset: clears the text window, byte and match counters, and sets the
//   pattern length to one. Pattern bytes are undefined until written.
// Stall: when a result waits and m_axis_tready is low the result register holds; the input
//   register still takes one more word if it is empty, then s_axis_tready drops.
`timescale 1ns / 1ps
`include "exact_pattern_match_counter_macros.svh"

module exact_pattern_match_counter
    import epmc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,   // byte_value[7:0], pattern_index[12:8], zero pad
    input  logic [1:0]       s_axis_tuser,   // func[1:0]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // start_offset[31:0], match_count[63:32]
    output logic [1:0]       m_axis_tuser    // found[0], text_done[1]
);

    logic                   in_valid_reg;
    func_t                  in_func_reg;
    logic [7:0]             in_byte_reg;
    logic [4:0]             in_index_reg;

    logic                   out_valid_reg;
    logic                   out_found_reg;
    logic                   out_done_reg;
    logic [CNT_W-1:0]       out_offset_reg;
    logic [CNT_W-1:0]       out_count_reg;

    byte_vec_t              pattern_reg;
    byte_vec_t              pattern_next;
    byte_vec_t              pattern_rev;
    byte_vec_t              aligned_reg;
    byte_vec_t              aligned_next;
    logic [PATTERN_MAX-1:0] mask_reg;
    logic [PATTERN_MAX-1:0] mask_next;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic [IDX_W-1:0]       shift_amt;

    byte_vec_t              window_reg;
    byte_vec_t              window_next;
    byte_vec_t              win_shift;
    logic [CNT_W-1:0]       seen_reg;
    logic [CNT_W-1:0]       seen_next;
    logic [CNT_W-1:0]       seen_inc;
    logic [CNT_W-1:0]       occ_reg;
    logic [CNT_W-1:0]       occ_next;
    logic [CNT_W-1:0]       occ_inc;
    logic [PATTERN_MAX-1:0] hit;
    logic                   window_match;

    logic                   found_next;
    logic                   done_next;
    logic [CNT_W-1:0]       offset_next;
    logic [CNT_W-1:0]       count_next;

    logic                   advance;
    logic                   fire;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_count_reg, out_offset_reg};
    assign m_axis_tuser  = {out_done_reg, out_found_reg};

    // pattern write, window compare, counter update and end-of-text clear
    always_comb
    begin
        pattern_next = pattern_reg;
        window_next  = window_reg;
        seen_next    = seen_reg;
        occ_next     = occ_reg;
        found_next   = 1'b0;
        done_next    = 1'b0;
        offset_next  = '0;
        count_next   = occ_reg;

        seen_inc  = (seen_reg == CNT_MAX) ? seen_reg : seen_reg + CNT_W'(1);
        occ_inc   = (occ_reg == CNT_MAX) ? occ_reg : occ_reg + CNT_W'(1);
        win_shift = {window_reg[PATTERN_MAX-2:0], in_byte_reg};

        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            hit[j] = (win_shift[j] == aligned_reg[j]) || !mask_reg[j];
        end
        window_match = (&hit) && (seen_inc >= CNT_W'(len_reg));

        if (fire)
        begin
            unique case (in_func_reg)
                FUNC_PATTERN:
                begin
                    for (int k = 0; k < PATTERN_MAX; k++)
                    begin
                        if (int'(in_index_reg) == k)
                        begin
                            pattern_next[k] = in_byte_reg;
                        end
                    end
                end
                FUNC_TEXT:
                begin
                    window_next = win_shift;
                    seen_next   = seen_inc;
                    if (window_match)
                    begin
                        found_next  = 1'b1;
                        offset_next = seen_inc - CNT_W'(len_reg);
                        occ_next    = occ_inc;
                        count_next  = occ_inc;
                    end
                end
                FUNC_END:
                begin
                    done_next = 1'b1;
                    occ_next  = '0;
                    seen_next = '0;
                end
                FUNC_NONE:
                begin
                end
            endcase
        end
    end

    // pattern copy aligned to the window: aligned[j] = pattern[len-1-j]
    always_comb
    begin
        len_next  = cfg_wr_en ? eff_length(cfg_wr_data) : len_reg;
        shift_amt = IDX_W'(PATTERN_MAX - int'(len_next));
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pattern_rev[i] = pattern_next[PATTERN_MAX-1-i];
            mask_next[i]   = (i < int'(len_next));
        end
        aligned_next = pattern_rev >> {shift_amt, 3'b000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            len_reg       <= LEN_W'(1);
            mask_reg      <= PATTERN_MAX'(1);
            window_reg    <= '0;
            seen_reg      <= '0;
            occ_reg       <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            len_reg    <= len_next;
            mask_reg   <= mask_next;
            window_reg <= window_next;
            seen_reg   <= seen_next;
            occ_reg    <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pattern_reg <= pattern_next;
        aligned_reg <= aligned_next;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_func_reg  <= func_t'(s_axis_tuser);
            in_byte_reg  <= s_axis_tdata[7:0];
            in_index_reg <= s_axis_tdata[12:8];
        end
        if (fire)
        begin
            out_found_reg  <= found_next;
            out_done_reg   <= done_next;
            out_offset_reg <= offset_next;
            out_count_reg  <= count_next;
        end
    end

    `EPMC_ASSERT(a_len_nonzero, mask_reg[0], "pattern mask lost its first byte")
    `EPMC_ASSERT_IMP(a_found_not_done, out_valid_reg && out_found_reg, !out_done_reg,
        "result flags both a match and end of text")
    `EPMC_ASSERT_IMP(a_found_counted, out_valid_reg && out_found_reg, out_count_reg != '0,
        "match reported with zero count")
    `EPMC_ASSERT_NEXT(a_count_monotonic, fire && (in_func_reg != FUNC_END),
        occ_reg >= $past(occ_reg), "match count decreased without end of text")

endmodule
